/* hw/rtl/crs_pkg.sv */
// Shared types, widths and codes for the credential rotation selector.
package crs_pkg;

    // Default sizes handed to the top level
    localparam int TABLE_DEPTH_DEF = 1024;
    localparam int ACL_DEPTH_DEF   = 256;

    // Field widths
    localparam int TIME_W   = 64;
    localparam int USE_W    = 32;
    localparam int SUM_W    = 40;
    localparam int SEL_W    = 10;
    localparam int CNT_W    = 11;
    localparam int LEN_W    = 8;
    localparam int MODE_W   = 3;
    localparam int BUF_W    = 9;
    localparam int STATUS_W = 3;
    localparam int QUOT_W   = 50;   // use_sum * 1000 fits in 50 bits
    localparam int PADDR_W  = 4;
    localparam int PDATA_W  = 32;

    // Rotation modes
    localparam logic [MODE_W-1:0] MODE_OLDEST = 3'd1;
    localparam logic [MODE_W-1:0] MODE_LEAST  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_RATIO  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_NEWEST = 3'd4;

    // Status codes
    localparam logic [STATUS_W-1:0] STATUS_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_BAD_PARAM = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_LOCKED    = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_NAME_LONG = 3'd4;

    // Register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_ROTATION_MODE = 2'd0;
    localparam logic [1:0] REG_STORE_LOCKED  = 2'd1;
    localparam logic [1:0] REG_NAME_BUF_SIZE = 2'd2;

    // Register reset values
    localparam logic [MODE_W-1:0] MODE_RESET = 3'd1;
    localparam logic [BUF_W-1:0]  BUF_RESET  = 9'd256;

    // Saturation limits
    localparam logic [SUM_W-1:0] SUM_MAX   = '1;
    localparam logic [CNT_W-1:0] COUNT_MAX = '1;

    // Input beat
    typedef struct packed {
        logic              record_valid;
        logic              in_group;
        logic [TIME_W-1:0] updated_time;
        logic              acl_valid;
        logic [USE_W-1:0]  access_uses;
        logic [USE_W-1:0]  access_limit;
        logic [LEN_W-1:0]  name_length;
        logic              end_of_credential;
        logic              end_of_table;
    } crs_item_t;

    // Result beat
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SEL_W-1:0]    selected_index;
        logic [TIME_W-1:0]   win_score;
        logic [CNT_W-1:0]    scored_total;
    } crs_result_t;

    // Configuration register values
    typedef struct packed {
        logic [MODE_W-1:0] rotation_mode;
        logic              store_locked;
        logic [BUF_W-1:0]  name_buffer_size;
    } crs_cfg_t;

    // Divider status toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } crs_div_stat_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLOSE,
        ST_DIVIDE,
        ST_UPDATE,
        ST_REPORT
    } crs_state_t;

endpackage

/* hw/rtl/crs_apb_regs.sv */
// APB configuration registers: rotation mode, store lock, name buffer size.
module crs_apb_regs (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [crs_pkg::PADDR_W-1:0] paddr,
    input  logic [crs_pkg::PDATA_W-1:0] pwdata,
    output logic [crs_pkg::PDATA_W-1:0] prdata,
    output logic                        pready,
    output crs_pkg::crs_cfg_t           cfg
);
    import crs_pkg::*;

    crs_cfg_t   cfg_reg;
    crs_cfg_t   cfg_next;
    logic [1:0] reg_idx;
    logic       wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;
    assign cfg     = cfg_reg;

    // Write decode
    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (reg_idx)
                REG_ROTATION_MODE: cfg_next.rotation_mode    = pwdata[MODE_W-1:0];
                REG_STORE_LOCKED:  cfg_next.store_locked     = pwdata[0];
                REG_NAME_BUF_SIZE: cfg_next.name_buffer_size = pwdata[BUF_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.rotation_mode    <= MODE_RESET;
            cfg_reg.store_locked     <= 1'b0;
            cfg_reg.name_buffer_size <= BUF_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Read mux
    always_comb begin
        case (reg_idx)
            REG_ROTATION_MODE: prdata = PDATA_W'(cfg_reg.rotation_mode);
            REG_STORE_LOCKED:  prdata = PDATA_W'(cfg_reg.store_locked);
            REG_NAME_BUF_SIZE: prdata = PDATA_W'(cfg_reg.name_buffer_size);
            default:           prdata = '0;
        endcase
    end

endmodule

/* hw/rtl/crs_divider.sv */
// Radix-2 restoring divider for the usage ratio: (num * 1000) / den, one bit a cycle.
module crs_divider (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [crs_pkg::SUM_W-1:0]  num,
    input  logic [crs_pkg::SUM_W-1:0]  den,
    output crs_pkg::crs_div_stat_t     stat,
    output logic [crs_pkg::QUOT_W-1:0] quot
);
    import crs_pkg::*;

    localparam int STEP_W = $clog2(QUOT_W + 1);

    logic [QUOT_W-1:0] work_reg, work_next;   // dividend bits shift out, quotient bits in
    logic [SUM_W:0]    rem_reg, rem_next;
    logic [SUM_W-1:0]  den_reg, den_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [SUM_W:0]    rem_shift;
    logic              fits;
    logic [QUOT_W-1:0] num_ext;

    assign num_ext   = QUOT_W'(num);
    assign rem_shift = {rem_reg[SUM_W-1:0], work_reg[QUOT_W-1]};
    assign fits      = rem_shift >= {1'b0, den_reg};

    always_comb begin
        work_next = work_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            // num * 1000 = (num << 10) - (num << 4) - (num << 3)
            work_next = (num_ext << 10) - (num_ext << 4) - (num_ext << 3);
            rem_next  = '0;
            den_next  = den;
            step_next = STEP_W'(QUOT_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            // One quotient bit per cycle
            rem_next  = fits ? (rem_shift - {1'b0, den_reg}) : rem_shift;
            work_next = {work_reg[QUOT_W-2:0], fits};
            step_next = step_reg - STEP_W'(1);
            if (step_reg == STEP_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        work_reg <= work_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quot      = work_reg;

endmodule

/* hw/rtl/credential_rotation_selector.sv */
// Credential rotation selector top level: scan sequencer, scoring and result register.
//
//  channel | ports                        | beat
//  --------+------------------------------+------------------------------------------
//  input   | s_valid s_ready s_data       | one access-list record of a credential
//  result  | m_valid m_ready m_data       | status and winner, once per table
//  config  | psel penable pwrite paddr .. | mode, lock, name buffer size at 4*index
//
//  A credential close runs the close and update states; for an in-group credential in
//  usage ratio mode with a nonzero limit sum it also waits in the divide state, where the
//  shared radix-2 divider produces one quotient bit a cycle. The end of table adds the
//  report state, which waits while a previous result still sits in the output register.
//  Reset is synchronous on aresetn; s_ready is high only while idle.
module credential_rotation_selector #(
    parameter int TABLE_DEPTH = crs_pkg::TABLE_DEPTH_DEF,
    parameter int ACL_DEPTH   = crs_pkg::ACL_DEPTH_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  crs_pkg::crs_item_t          s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output crs_pkg::crs_result_t        m_data,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [crs_pkg::PADDR_W-1:0] paddr,
    input  logic [crs_pkg::PDATA_W-1:0] pwdata,
    output logic [crs_pkg::PDATA_W-1:0] prdata,
    output logic                        pready
);
    import crs_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH + 1);
    localparam int ACL_W = $clog2(ACL_DEPTH + 1);
    localparam logic [IDX_W-1:0] IDX_LIMIT = IDX_W'(TABLE_DEPTH);
    localparam logic [ACL_W-1:0] ACL_LIMIT = ACL_W'(ACL_DEPTH);

    crs_cfg_t      cfg;
    crs_div_stat_t div_stat;
    logic [QUOT_W-1:0] div_quot;
    logic          div_start;

    crs_state_t    state_reg, state_next;
    crs_item_t     item_reg, item_next;
    logic [IDX_W-1:0] cred_idx_reg, cred_idx_next;
    logic [SUM_W-1:0] use_sum_reg, use_sum_next;
    logic [SUM_W-1:0] limit_sum_reg, limit_sum_next;
    logic [ACL_W-1:0] acl_count_reg, acl_count_next;
    logic [SEL_W-1:0] best_index_reg, best_index_next;
    logic [TIME_W-1:0] best_value_reg, best_value_next;
    logic [LEN_W-1:0] best_len_reg, best_len_next;
    logic          found_any_reg, found_any_next;
    logic [CNT_W-1:0] scored_count_reg, scored_count_next;
    logic          mode_error_reg, mode_error_next;
    logic [TIME_W-1:0] score_reg, score_next;
    logic          score_ok_reg, score_ok_next;
    crs_result_t   out_reg, out_next;
    logic          m_valid_reg, m_valid_next;

    logic          in_beat;
    logic          out_free;
    logic [SUM_W:0] use_add;
    logic [SUM_W:0] limit_add;
    logic [STATUS_W-1:0] status_sel;

    crs_apb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    crs_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (use_sum_reg),
        .den     (limit_sum_reg),
        .stat    (div_stat),
        .quot    (div_quot)
    );

    assign s_ready  = (state_reg == ST_IDLE);
    assign in_beat  = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = out_reg;

    // Saturating sums of the current credential
    assign use_add   = {1'b0, use_sum_reg} + (SUM_W+1)'(s_data.access_uses);
    assign limit_add = {1'b0, limit_sum_reg} + (SUM_W+1)'(s_data.access_limit);

    // Status with its precedence
    always_comb begin
        if (cfg.name_buffer_size == '0) begin
            status_sel = STATUS_BAD_PARAM;
        end else if (cfg.store_locked) begin
            status_sel = STATUS_LOCKED;
        end else if (mode_error_reg) begin
            status_sel = STATUS_BAD_PARAM;
        end else if (!found_any_reg) begin
            status_sel = STATUS_NOT_FOUND;
        end else if (BUF_W'(best_len_reg) >= cfg.name_buffer_size) begin
            status_sel = STATUS_NAME_LONG;
        end else begin
            status_sel = STATUS_OK;
        end
    end

    // Sequencer: next state and datapath updates
    always_comb begin
        state_next        = state_reg;
        item_next         = item_reg;
        cred_idx_next     = cred_idx_reg;
        use_sum_next      = use_sum_reg;
        limit_sum_next    = limit_sum_reg;
        acl_count_next    = acl_count_reg;
        best_index_next   = best_index_reg;
        best_value_next   = best_value_reg;
        best_len_next     = best_len_reg;
        found_any_next    = found_any_reg;
        scored_count_next = scored_count_reg;
        mode_error_next   = mode_error_reg;
        score_next        = score_reg;
        score_ok_next     = score_ok_reg;
        out_next          = out_reg;
        m_valid_next      = m_valid_reg && !m_ready;
        div_start         = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (in_beat) begin
                    item_next = s_data;
                    // Accumulate one access-list entry
                    if (s_data.record_valid && s_data.acl_valid &&
                        acl_count_reg < ACL_LIMIT) begin
                        use_sum_next   = use_add[SUM_W] ? SUM_MAX : use_add[SUM_W-1:0];
                        limit_sum_next = limit_add[SUM_W] ? SUM_MAX : limit_add[SUM_W-1:0];
                        acl_count_next = acl_count_reg + ACL_W'(1);
                    end
                    if (s_data.record_valid &&
                        (s_data.end_of_credential || s_data.end_of_table)) begin
                        state_next = ST_CLOSE;
                    end else if (s_data.end_of_table) begin
                        state_next = ST_REPORT;
                    end
                end
            end

            ST_CLOSE: begin
                // Score the closing credential
                score_ok_next = 1'b0;
                state_next    = ST_UPDATE;
                if (item_reg.in_group && cred_idx_reg < IDX_LIMIT) begin
                    score_ok_next = 1'b1;
                    case (cfg.rotation_mode)
                        MODE_OLDEST: score_next = item_reg.updated_time;
                        MODE_LEAST:  score_next = TIME_W'(use_sum_reg);
                        MODE_RATIO: begin
                            if (limit_sum_reg == '0) begin
                                score_next = TIME_W'(use_sum_reg);
                            end else begin
                                div_start  = 1'b1;
                                state_next = ST_DIVIDE;
                            end
                        end
                        MODE_NEWEST: score_next = ~item_reg.updated_time;
                        default: begin
                            score_ok_next   = 1'b0;
                            mode_error_next = 1'b1;
                        end
                    endcase
                end
                use_sum_next   = '0;
                limit_sum_next = '0;
                acl_count_next = '0;
            end

            ST_DIVIDE: begin
                if (div_stat.done) begin
                    score_next = TIME_W'(div_quot);
                    state_next = ST_UPDATE;
                end
            end

            ST_UPDATE: begin
                // Keep the first lowest score
                if (score_ok_reg) begin
                    if (scored_count_reg != COUNT_MAX) begin
                        scored_count_next = scored_count_reg + CNT_W'(1);
                    end
                    if (!found_any_reg || score_reg < best_value_reg) begin
                        best_index_next = SEL_W'(cred_idx_reg);
                        best_value_next = score_reg;
                        best_len_next   = item_reg.name_length;
                        found_any_next  = 1'b1;
                    end
                end
                if (cred_idx_reg < IDX_LIMIT) begin
                    cred_idx_next = cred_idx_reg + IDX_W'(1);
                end
                state_next = item_reg.end_of_table ? ST_REPORT : ST_IDLE;
            end

            ST_REPORT: begin
                // Load the result once the output register is free, then clear the scan
                if (out_free) begin
                    out_next.status       = status_sel;
                    out_next.scored_total = scored_count_reg;
                    if (status_sel == STATUS_OK || status_sel == STATUS_NAME_LONG) begin
                        out_next.selected_index = best_index_reg;
                        out_next.win_score      = best_value_reg;
                    end else begin
                        out_next.selected_index = '0;
                        out_next.win_score      = '0;
                    end
                    m_valid_next      = 1'b1;
                    cred_idx_next     = '0;
                    use_sum_next      = '0;
                    limit_sum_next    = '0;
                    acl_count_next    = '0;
                    best_index_next   = '0;
                    best_value_next   = '0;
                    best_len_next     = '0;
                    found_any_next    = 1'b0;
                    scored_count_next = '0;
                    mode_error_next   = 1'b0;
                    state_next        = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Scan state and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cred_idx_reg     <= '0;
            use_sum_reg      <= '0;
            limit_sum_reg    <= '0;
            acl_count_reg    <= '0;
            best_index_reg   <= '0;
            best_value_reg   <= '0;
            best_len_reg     <= '0;
            found_any_reg    <= 1'b0;
            scored_count_reg <= '0;
            mode_error_reg   <= 1'b0;
            score_ok_reg     <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            cred_idx_reg     <= cred_idx_next;
            use_sum_reg      <= use_sum_next;
            limit_sum_reg    <= limit_sum_next;
            acl_count_reg    <= acl_count_next;
            best_index_reg   <= best_index_next;
            best_value_reg   <= best_value_next;
            best_len_reg     <= best_len_next;
            found_any_reg    <= found_any_next;
            scored_count_reg <= scored_count_next;
            mode_error_reg   <= mode_error_next;
            score_ok_reg     <= score_ok_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        item_reg  <= item_next;
        score_reg <= score_next;
        out_reg   <= out_next;
    end

    // While dividing, the divider is either running or just finished
    a_div_active: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIVIDE && !div_stat.done) |-> div_stat.busy)
        else $error("divider idle while sequencer waits on it");

    // A new result only comes out of the report step
    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_REPORT))
        else $error("result raised outside report step");

    // Scored credentials never outnumber closed ones
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(scored_count_reg) <= 32'(cred_idx_reg))
        else $error("scored count exceeds credential index");

    // No winner means nothing was scored
    a_found_count: assert property (@(posedge aclk) disable iff (!aresetn)
        !found_any_reg |-> (scored_count_reg == '0))
        else $error("scored credentials without a winner");

endmodule
